/* sv/vhd_pkg.sv */
// Shared types, constants and the sequencer program of the velocity hit detector.
package vhd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int DIV_W    = 17;
    localparam int OUT_W    = 8;
    localparam int PC_W     = 4;
    localparam int CFG_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic [TIME_W-1:0]   WINDOW_US     = 32'd100;
    localparam logic [DIV_W-1:0]    FLOOR_MARGIN  = 17'd3;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd80;
    localparam logic [DIV_W-1:0]    IN_HIGH_RST   = 17'd65536;
    localparam logic [OUT_W-1:0]    OUT_HIGH_RST  = 8'd255;
    localparam logic [TIME_W-1:0]   HOLD_OFF_RST  = 32'd10000;
    localparam logic [DIV_W-1:0]    SPAN_RST      = 17'd257;

    typedef enum logic [ADDR_W-1:0] {
        REG_VELOCITY_MODE = 3'd0,
        REG_THRESHOLD     = 3'd1,
        REG_IN_LOW        = 3'd2,
        REG_IN_HIGH       = 3'd3,
        REG_OUT_LOW       = 3'd4,
        REG_OUT_HIGH      = 3'd5,
        REG_HOLD_OFF_US   = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_TEST,
        OP_LOAD_CFG,
        OP_DIV_STEP,
        OP_STORE_SPAN,
        OP_UPDATE,
        OP_LOAD_SAMPLE,
        OP_CLAMP,
        OP_HOLD,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_CLEAN,
        C_DIV_MORE,
        C_NO_DIV,
        C_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic dirty;
        logic div_more;
        logic need_div;
        logic out_blocked;
    } vhd_flags_t;

    localparam logic [PC_W-1:0] PC_WAIT      = 4'd0;
    localparam logic [PC_W-1:0] PC_CFG_DIV   = 4'd3;
    localparam logic [PC_W-1:0] PC_UPDATE    = 4'd5;
    localparam logic [PC_W-1:0] PC_SMP_DIV   = 4'd7;
    localparam logic [PC_W-1:0] PC_HOLD      = 4'd9;

    // Jump taken when the condition holds, otherwise fall through to the next step.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{OP_WAIT,        C_NO_ACCEPT,   PC_WAIT};
            4'd1:    w = '{OP_TEST,        C_CLEAN,       PC_UPDATE};
            4'd2:    w = '{OP_LOAD_CFG,    C_NEVER,       PC_WAIT};
            4'd3:    w = '{OP_DIV_STEP,    C_DIV_MORE,    PC_CFG_DIV};
            4'd4:    w = '{OP_STORE_SPAN,  C_NEVER,       PC_WAIT};
            4'd5:    w = '{OP_UPDATE,      C_NEVER,       PC_WAIT};
            4'd6:    w = '{OP_LOAD_SAMPLE, C_NO_DIV,      PC_HOLD};
            4'd7:    w = '{OP_DIV_STEP,    C_DIV_MORE,    PC_SMP_DIV};
            4'd8:    w = '{OP_CLAMP,       C_NEVER,       PC_WAIT};
            4'd9:    w = '{OP_HOLD,        C_OUT_BLOCKED, PC_HOLD};
            4'd10:   w = '{OP_EMIT,        C_ALWAYS,      PC_WAIT};
            default: w = '{OP_WAIT,        C_ALWAYS,      PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* sv/vhd_div.sv */
// Restoring divider, one quotient bit per step.
module vhd_div
    import vhd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic             step,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             more
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next = {quo_reg[DIV_W-2:0], fits};
        rem_next = fits ? DIV_W'(trial - {1'b0, dsr_reg}) : trial[DIV_W-1:0];
        cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= CNT_W'(DIV_W);
        end else if (step) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign more     = cnt_reg > CNT_W'(1);

endmodule

/* sv/vhd_useq.sv */
// Step counter and branch logic driving the control word from the program table.
module vhd_useq
    import vhd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  vhd_flags_t flags,
    output ucode_t     uword
);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            taken;

    assign uword = ucode_rom(pc_reg);

    always_comb begin
        case (uword.cond)
            C_NEVER:       taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_NO_ACCEPT:   taken = !flags.accept;
            C_CLEAN:       taken = !flags.dirty;
            C_DIV_MORE:    taken = flags.div_more;
            C_NO_DIV:      taken = !flags.need_div;
            C_OUT_BLOCKED: taken = flags.out_blocked;
            default:       taken = 1'b0;
        endcase
        pc_next = taken ? uword.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* sv/velocity_hit_detector.sv */
// Velocity hit detector: microcoded control around a shared iterative divider.
// Per item: test for a pending span divisor rebuild, update the detector state, then,
// when a sample or peak is scaled, divide (17 divider steps) and clamp; wait while the
// output is blocked, then emit. The rebuild runs first after reset or after a write to
// in_low, in_high, out_low or out_high. A new item is accepted only after the emit.
// Reset (aresetn low, synchronous) restores register defaults and detector state.
module velocity_hit_detector
    import vhd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,     // sample[15:0], now_us[47:16]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,     // event_valid[0], event_value[8:1],
                                           // pressure_valid[9], pressure_value[17:10]
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wr_data
);

    ucode_t     uword;
    vhd_flags_t flags;
    logic       accept;

    // configuration
    logic                velocity_mode_reg;
    logic [SAMPLE_W-1:0] threshold_reg;
    logic [SAMPLE_W-1:0] in_low_reg;
    logic [DIV_W-1:0]    in_high_reg;
    logic [OUT_W-1:0]    out_low_reg;
    logic [OUT_W-1:0]    out_high_reg;
    logic [TIME_W-1:0]   hold_off_reg;
    logic                dirty_reg;
    logic [DIV_W-1:0]    span_reg;

    // detector state
    logic                holding_reg, holding_next;
    logic [TIME_W-1:0]   mark_reg, mark_next;
    logic                note_reg, note_next;
    logic                await_reg, await_next;
    logic [SAMPLE_W-1:0] wh_reg, wh_next;
    logic [SAMPLE_W-1:0] wl_reg, wl_next;

    // item payload and working results
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [SAMPLE_W-1:0]    s16;
    logic [TIME_W-1:0]      elapsed;
    logic                   ev_reg, ev_next;
    logic [OUT_W-1:0]       evv_reg, evv_next;
    logic                   pv_reg, pv_next;
    logic [OUT_W-1:0]       pvv_reg, pvv_next;
    logic                   need_reg, need_next;
    logic                   sel_high_reg, sel_high_next;
    logic [SAMPLE_W-1:0]    opnd_reg, opnd_next;

    // divider hookup
    logic             div_load;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_q;
    logic             div_more;
    logic [OUT_W-1:0] ospan;
    logic [DIV_W-1:0] in_span;
    logic [OUT_W-1:0] clamped;

    // output register
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    assign s_tready = (uword.op == OP_WAIT);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign flags = '{accept:      accept,
                     dirty:       dirty_reg,
                     div_more:    div_more,
                     need_div:    need_reg,
                     out_blocked: m_tvalid_reg && !m_tready};

    vhd_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword)
    );

    always_comb begin
        ospan = (out_high_reg >= out_low_reg) ? out_high_reg - out_low_reg
                                              : out_low_reg - out_high_reg;
        if (ospan == '0) begin
            ospan = OUT_W'(1);
        end
        in_span      = in_high_reg - {1'b0, in_low_reg};
        div_load     = (uword.op == OP_LOAD_CFG) || (uword.op == OP_LOAD_SAMPLE && need_reg);
        div_dividend = (uword.op == OP_LOAD_CFG) ? in_span : {1'b0, opnd_reg};
        div_divisor  = (uword.op == OP_LOAD_CFG) ? {{(DIV_W-OUT_W){1'b0}}, ospan} : span_reg;
    end

    vhd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (div_load),
        .step     (uword.op == OP_DIV_STEP),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .more     (div_more)
    );

    // low bound first, then high bound, also when the bounds are reversed
    always_comb begin
        if (div_q < {{(DIV_W-OUT_W){1'b0}}, out_low_reg}) begin
            clamped = out_low_reg;
        end else if (div_q > {{(DIV_W-OUT_W){1'b0}}, out_high_reg}) begin
            clamped = out_high_reg;
        end else begin
            clamped = div_q[OUT_W-1:0];
        end
    end

    assign s16     = SAMPLE_W'(smp_reg);
    assign elapsed = now_reg - mark_reg;

    always_comb begin
        holding_next  = holding_reg;
        mark_next     = mark_reg;
        note_next     = note_reg;
        await_next    = await_reg;
        wh_next       = wh_reg;
        wl_next       = wl_reg;
        ev_next       = 1'b0;
        evv_next      = '0;
        pv_next       = 1'b0;
        pvv_next      = '0;
        need_next     = 1'b0;
        sel_high_next = 1'b0;
        opnd_next     = s16;
        if (holding_reg) begin
            if (elapsed > hold_off_reg &&
                {1'b0, s16} <= {1'b0, in_low_reg} + FLOOR_MARGIN) begin
                holding_next = 1'b0;
                mark_next    = now_reg;
            end
        end else if (velocity_mode_reg) begin
            if (note_reg) begin
                if (s16 < threshold_reg) begin
                    ev_next      = 1'b1;
                    evv_next     = out_low_reg;
                    pv_next      = 1'b1;
                    note_next    = 1'b0;
                    holding_next = 1'b1;
                    wh_next      = '0;
                    wl_next      = threshold_reg;
                    mark_next    = now_reg;
                end else begin
                    pv_next   = 1'b1;
                    need_next = 1'b1;
                end
            end else begin
                if (s16 > wh_reg) begin
                    wh_next = s16;
                end else if (s16 < wl_reg && !await_reg) begin
                    wl_next = s16;
                end
                if (elapsed >= WINDOW_US) begin
                    if (await_reg) begin
                        // listening window over: scale the peak as velocity
                        ev_next       = 1'b1;
                        need_next     = 1'b1;
                        sel_high_next = 1'b1;
                        opnd_next     = wh_next;
                        note_next     = 1'b1;
                        await_next    = 1'b0;
                    end else if (wh_next > wl_next &&
                                 wh_next - wl_next > threshold_reg) begin
                        await_next = 1'b1;
                    end else begin
                        wh_next = '0;
                        wl_next = threshold_reg;
                    end
                    mark_next = now_reg;
                end
            end
        end else begin
            if (!note_reg && s16 > threshold_reg) begin
                ev_next   = 1'b1;
                evv_next  = out_high_reg;
                note_next = 1'b1;
            end else if (note_reg && s16 <= threshold_reg) begin
                ev_next      = 1'b1;
                evv_next     = out_low_reg;
                note_next    = 1'b0;
                holding_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            velocity_mode_reg <= 1'b0;
            threshold_reg     <= THRESHOLD_RST;
            in_low_reg        <= '0;
            in_high_reg       <= IN_HIGH_RST;
            out_low_reg       <= '0;
            out_high_reg      <= OUT_HIGH_RST;
            hold_off_reg      <= HOLD_OFF_RST;
            dirty_reg         <= 1'b1;
            span_reg          <= SPAN_RST;
            holding_reg       <= 1'b0;
            mark_reg          <= '0;
            note_reg          <= 1'b0;
            await_reg         <= 1'b0;
            wh_reg            <= '0;
            wl_reg            <= THRESHOLD_RST;
            need_reg          <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (uword.op == OP_STORE_SPAN) begin
                if (in_high_reg <= {1'b0, in_low_reg} || div_q == '0) begin
                    span_reg <= DIV_W'(1);
                end else begin
                    span_reg <= div_q;
                end
                dirty_reg <= 1'b0;
            end
            if (uword.op == OP_UPDATE) begin
                holding_reg <= holding_next;
                mark_reg    <= mark_next;
                note_reg    <= note_next;
                await_reg   <= await_next;
                wh_reg      <= wh_next;
                wl_reg      <= wl_next;
                need_reg    <= need_next;
            end
            if (uword.op == OP_EMIT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_addr))
                    REG_VELOCITY_MODE: velocity_mode_reg <= cfg_wr_data[0];
                    REG_THRESHOLD:     threshold_reg     <= cfg_wr_data[SAMPLE_W-1:0];
                    REG_IN_LOW: begin
                        in_low_reg <= cfg_wr_data[SAMPLE_W-1:0];
                        dirty_reg  <= 1'b1;
                    end
                    REG_IN_HIGH: begin
                        in_high_reg <= cfg_wr_data[DIV_W-1:0];
                        dirty_reg   <= 1'b1;
                    end
                    REG_OUT_LOW: begin
                        out_low_reg <= cfg_wr_data[OUT_W-1:0];
                        dirty_reg   <= 1'b1;
                    end
                    REG_OUT_HIGH: begin
                        out_high_reg <= cfg_wr_data[OUT_W-1:0];
                        dirty_reg    <= 1'b1;
                    end
                    REG_HOLD_OFF_US:   hold_off_reg      <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            smp_reg <= s_tdata[SAMPLE_BITS-1:0];
            now_reg <= s_tdata[47:16];
        end
        if (uword.op == OP_UPDATE) begin
            ev_reg       <= ev_next;
            evv_reg      <= evv_next;
            pv_reg       <= pv_next;
            pvv_reg      <= pvv_next;
            sel_high_reg <= sel_high_next;
            opnd_reg     <= opnd_next;
        end
        if (uword.op == OP_CLAMP) begin
            if (sel_high_reg) begin
                evv_reg <= clamped;
            end else begin
                pvv_reg <= clamped;
            end
        end
        if (uword.op == OP_EMIT) begin
            m_tdata_reg <= {6'd0, pvv_reg, pv_reg, evv_reg, ev_reg};
        end
    end

    a_span_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        span_reg != '0)
        else $error("span divisor is zero");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("item accepted while previous item in progress");

    a_no_event_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tdata_reg[0]) |-> (m_tdata_reg[8:1] == '0))
        else $error("event value set without event");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == OP_EMIT) |-> !m_tvalid_reg)
        else $error("result overwritten before taken");

endmodule
